FILE: rtl/machine_check_recovery_classifier_top_macros.svh
// Assertion macros used by the machine-check classifier checker.
`ifndef MACHINE_CHECK_RECOVERY_CLASSIFIER_TOP_MACROS_SVH
`define MACHINE_CHECK_RECOVERY_CLASSIFIER_TOP_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define MCRC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition that must never be seen outside reset.
`define MCRC_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define MCRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/mcrc_pkg.sv
// Types and constants of the machine-check recovery classifier.
`timescale 1ns / 1ps
package mcrc_pkg;

    localparam int TYPE_COUNT = 16;
    localparam int KIND_W     = 4;

    localparam int CODE_W   = 9;
    localparam int PARITY_W = 10;
    localparam int OP_W     = 8;
    localparam int SEC_W    = 32;
    localparam int CNT_W    = 16;
    localparam int WORD_W   = 22;

    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 48;

    localparam logic [CODE_W-1:0]   PREFETCH_BIT = 9'h008;
    localparam logic [CODE_W-1:0]   ABORT_BITS   = 9'h0f0;
    localparam logic [CODE_W-1:0]   TIMEOUT_BIT  = 9'h100;
    localparam logic [PARITY_W-1:0] GROUP0_OK    = 10'h3f8;

    localparam logic [WORD_W-1:0] G1_REPLACE = 22'h002000;
    localparam logic [WORD_W-1:0] G0_REPLACE = 22'h004000;
    localparam logic [WORD_W-1:0] G1_MISS    = 22'h008000;
    localparam logic [WORD_W-1:0] G0_MISS    = 22'h010000;
    localparam logic [WORD_W-1:0] SBI_INVAL  = 22'h200000;

    localparam logic [CNT_W-1:0] CNT_MAX = 16'hffff;

    // Bit n is set when opcode n can be restarted after a check.
    localparam logic [255:0] RESUMABLE_OPS =
        256'h00ffff3f_f4ffffff_f3ffffff_ffffffff_c14a0f00_002fffff_feffff00_ffff3c3b;

    typedef enum logic [1:0] {
        OUT_RESUME = 2'd0,
        OUT_SIGNAL = 2'd1,
        OUT_PANIC  = 2'd2
    } t_outcome;

    typedef enum logic [2:0] {
        CLS_TBUF,
        CLS_NEVER,
        CLS_CACHE,
        CLS_PLAIN,
        CLS_MEMERR,
        CLS_UNKNOWN
    } t_class;

    // Decoded check handed from the front end to the back end.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        t_class            cls;
        logic              resume_ok;
        logic              g0_bad;
        logic [SEC_W-1:0]  now;
        logic              user;
    } t_cmd;

endpackage

FILE: rtl/mcrc_front.sv
// Front end: unpacks an incoming check and decodes its type.
`timescale 1ns / 1ps
module mcrc_front (
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [mcrc_pkg::IN_DATA_W-1:0]     i_data,
    output logic                               o_push,
    input  logic                               i_q_ready,
    output mcrc_pkg::t_cmd                     o_cmd
);

    logic [mcrc_pkg::CODE_W-1:0]   code;
    logic [mcrc_pkg::PARITY_W-1:0] parity;
    logic [mcrc_pkg::OP_W-1:0]     op;
    logic                          restartable;

    assign code   = i_data[8:0];
    assign parity = i_data[18:9];
    assign op     = i_data[26:19];

    assign restartable = mcrc_pkg::RESUMABLE_OPS[op];

    always_comb begin
        o_cmd.kind = code[mcrc_pkg::KIND_W-1:0];
        o_cmd.now  = i_data[58:27];
        o_cmd.user = i_data[59];
        // The same-second test is applied later; this covers the rest.
        o_cmd.resume_ok = ((code & (mcrc_pkg::ABORT_BITS | mcrc_pkg::TIMEOUT_BIT)) == '0)
                          && (((code & mcrc_pkg::PREFETCH_BIT) != '0) || restartable);
        o_cmd.g0_bad = (parity & mcrc_pkg::GROUP0_OK) != mcrc_pkg::GROUP0_OK;
        unique case (code[mcrc_pkg::KIND_W-1:0])
            4'd2, 4'd10:  o_cmd.cls = mcrc_pkg::CLS_TBUF;
            4'd1, 4'd6:   o_cmd.cls = mcrc_pkg::CLS_NEVER;
            4'd3, 4'd15:  o_cmd.cls = mcrc_pkg::CLS_CACHE;
            4'd0, 4'd13:  o_cmd.cls = mcrc_pkg::CLS_PLAIN;
            4'd5, 4'd12:  o_cmd.cls = mcrc_pkg::CLS_MEMERR;
            default:      o_cmd.cls = mcrc_pkg::CLS_UNKNOWN;
        endcase
    end

    assign o_ready = i_q_ready;
    assign o_push  = i_valid && i_q_ready;

endmodule

FILE: rtl/mcrc_queue.sv
// Two-entry queue between the front end and the back end.
`timescale 1ns / 1ps
module mcrc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_ready,
    input  mcrc_pkg::t_cmd i_cmd,
    output logic           o_valid,
    input  logic           i_pop,
    output mcrc_pkg::t_cmd o_cmd
);

    mcrc_pkg::t_cmd r_mem [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;
    logic [1:0]     n_count;

    assign o_ready = r_count != 2'd2;
    assign o_valid = r_count != 2'd0;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

FILE: rtl/mcrc_back.sv
// Back end: per-type counters and times, cache-disable word, result register.
`timescale 1ns / 1ps
module mcrc_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_pop,
    input  mcrc_pkg::t_cmd                  i_cmd,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [mcrc_pkg::OUT_DATA_W-1:0] o_data
);

    logic [mcrc_pkg::CNT_W-1:0]  r_counts [mcrc_pkg::TYPE_COUNT];
    logic [mcrc_pkg::SEC_W-1:0]  r_secs   [mcrc_pkg::TYPE_COUNT];
    logic [mcrc_pkg::WORD_W-1:0] r_word;
    logic [mcrc_pkg::WORD_W-1:0] n_word;
    logic [mcrc_pkg::CNT_W-1:0]  n_count;
    logic                        r_out_valid;
    logic [mcrc_pkg::OUT_DATA_W-1:0] r_out_data;
    logic [mcrc_pkg::OUT_DATA_W-1:0] n_out_data;

    logic                 take;
    logic                 uses_time;
    logic                 same_sec;
    logic                 recovered;
    mcrc_pkg::t_outcome   outcome;

    assign take  = i_valid && (!r_out_valid || i_ready);
    assign o_pop = take;

    assign uses_time = (i_cmd.cls == mcrc_pkg::CLS_TBUF) || (i_cmd.cls == mcrc_pkg::CLS_CACHE)
                       || (i_cmd.cls == mcrc_pkg::CLS_PLAIN);
    assign same_sec  = r_secs[i_cmd.kind] == i_cmd.now;
    assign recovered = uses_time && !same_sec && i_cmd.resume_ok;

    always_comb begin
        n_count = (r_counts[i_cmd.kind] == mcrc_pkg::CNT_MAX) ? r_counts[i_cmd.kind]
                                                               : r_counts[i_cmd.kind] + 16'd1;
        n_word = r_word;
        if (i_cmd.cls == mcrc_pkg::CLS_CACHE) begin
            if (i_cmd.g0_bad) begin
                n_word = (r_word | mcrc_pkg::G0_MISS | mcrc_pkg::G0_REPLACE)
                         & ~mcrc_pkg::G1_REPLACE;
            end else begin
                n_word = (r_word | mcrc_pkg::G1_MISS | mcrc_pkg::G1_REPLACE)
                         & ~mcrc_pkg::G0_REPLACE;
            end
        end
        priority if (i_cmd.cls == mcrc_pkg::CLS_UNKNOWN) begin
            outcome = mcrc_pkg::OUT_PANIC;
        end else if (recovered) begin
            outcome = mcrc_pkg::OUT_RESUME;
        end else begin
            outcome = i_cmd.user ? mcrc_pkg::OUT_SIGNAL : mcrc_pkg::OUT_PANIC;
        end
        n_out_data = {5'd0,
                      n_count,
                      i_cmd.cls == mcrc_pkg::CLS_UNKNOWN,
                      i_cmd.cls == mcrc_pkg::CLS_MEMERR,
                      n_word,
                      i_cmd.cls == mcrc_pkg::CLS_TBUF,
                      outcome};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < mcrc_pkg::TYPE_COUNT; i++) begin
                r_counts[i] <= '0;
                r_secs[i]   <= '0;
            end
            r_word      <= mcrc_pkg::SBI_INVAL;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_counts[i_cmd.kind] <= n_count;
                r_word               <= n_word;
                // A repeat within the same second leaves the stored time alone.
                if (uses_time && !same_sec) begin
                    r_secs[i_cmd.kind] <= i_cmd.now;
                end
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

endmodule

FILE: rtl/machine_check_recovery_classifier_top.sv
// Top level of the machine-check recovery classifier.
`timescale 1ns / 1ps
// Takes one machine-check transaction per clock while the queue has room and returns
// one result transaction for each, in order. A result is registered in the back end
// as its check leaves the queue; sustained throughput is one check per cycle while
// results are taken, set by the read-modify-write of the per-type count and time
// registers in the back end. A two-entry queue separates decode from execution so
// up to two checks are accepted while a result waits to be taken. Reset clears all
// counts and stored seconds and loads the cache-disable word with SBI invalidate alone.
module machine_check_recovery_classifier_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // type_code[8:0], parity_status[18:9], opcode[26:19], now_seconds[58:27],
    // user_mode[59], zero[63:60]
    input  logic [63:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // outcome[1:0], flush_translation_buffer[2], cache_control[24:3],
    // memory_error[25], unknown_type[26], type_count[42:27], zero[47:43]
    output logic [47:0] o_m_axis_tdata
);

    mcrc_pkg::t_cmd front_cmd;
    mcrc_pkg::t_cmd q_cmd;
    logic           push;
    logic           q_ready;
    logic           q_valid;
    logic           pop;

    mcrc_front u_front (
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_data    (i_s_axis_tdata),
        .o_push    (push),
        .i_q_ready (q_ready),
        .o_cmd     (front_cmd)
    );

    mcrc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_ready (q_ready),
        .i_cmd   (front_cmd),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_cmd   (q_cmd)
    );

    mcrc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_pop   (pop),
        .i_cmd   (q_cmd),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (o_m_axis_tdata)
    );

endmodule

FILE: rtl/mcrc_checker.sv
// Port-level checker for the machine-check classifier and its bind statement.
`timescale 1ns / 1ps
`include "machine_check_recovery_classifier_top_macros.svh"
module mcrc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [47:0] o_m_axis_tdata
);

    logic [1:0] outcome;
    logic       flush;
    logic       memerr;
    logic       unknown;

    assign outcome = o_m_axis_tdata[1:0];
    assign flush   = o_m_axis_tdata[2];
    assign memerr  = o_m_axis_tdata[25];
    assign unknown = o_m_axis_tdata[26];

    `MCRC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata), "stalled result changed")
    `MCRC_ASSERT_NEVER(a_outcome_code, i_clk, i_rst_n, o_m_axis_tvalid && outcome == 2'd3, "outcome code out of range")
    `MCRC_ASSERT_IMPL(a_unknown_panics, i_clk, i_rst_n, o_m_axis_tvalid && unknown, outcome == mcrc_pkg::OUT_PANIC && !flush && !memerr, "unknown type did not panic")
    `MCRC_ASSERT_IMPL(a_memerr_no_resume, i_clk, i_rst_n, o_m_axis_tvalid && memerr, outcome != mcrc_pkg::OUT_RESUME && !flush, "memory error resumed")
    `MCRC_ASSERT_IMPL(a_count_nonzero, i_clk, i_rst_n, o_m_axis_tvalid, o_m_axis_tdata[42:27] != 16'd0, "type count is zero")

endmodule

bind machine_check_recovery_classifier_top mcrc_checker u_mcrc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
